// ===== hw/rtl/bpsd_pkg.sv =====
// Shared types, codes and the single-wait update function for the button press
// sequence detector. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bpsd_pkg;

  localparam int TICK_W    = 10;
  localparam int COUNT_W   = 4;
  localparam int PHASE_W   = 3;
  localparam int STATUS_W  = 2;
  localparam int STARS_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  // Longest chain of waits that one sample can pass through, plus margin.
  localparam int FEED_STEPS = 4;

  localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_RELEASE   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PRESS     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_UNPRESS   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_QUIET     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_RECOVERED = 3'd5;
  localparam logic [PHASE_W-1:0] PH_FAILED    = 3'd6;

  localparam logic [STATUS_W-1:0] STATUS_IDLE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUSY      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RECOVERED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FAILED    = 2'd3;

  localparam logic [STARS_W-1:0] STARS_NONE  = 2'd0;
  localparam logic [STARS_W-1:0] STARS_ONE   = 2'd1;
  localparam logic [STARS_W-1:0] STARS_TWO   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_EDGE_TICKS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_EDGE_TICKS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_ONE_TICKS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_TWO_TICKS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_GROUP_PRESSES  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_GROUP_PRESSES = 3'd6;

  typedef struct packed {
    logic [TICK_W-1:0]  release_ticks;
    logic [TICK_W-1:0]  first_edge_ticks;
    logic [TICK_W-1:0]  next_edge_ticks;
    logic [TICK_W-1:0]  quiet_one_ticks;
    logic [TICK_W-1:0]  quiet_two_ticks;
    logic [COUNT_W-1:0] first_group_presses;
    logic [COUNT_W-1:0] second_group_presses;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TICK_W-1:0]  elapsed;
    logic [COUNT_W-1:0] presses_done;
    logic               second_group;
  } det_state_t;

  typedef struct packed {
    det_state_t st;
    logic       again;
  } feed_res_t;

  // One read of the current wait. The again flag says the same sample must
  // also be read by the wait that follows.
  function automatic feed_res_t feed(det_state_t s, cfg_t c, logic pr);
    feed_res_t          r;
    logic [TICK_W-1:0]  lim;
    logic               hit;
    logic               active;
    logic [COUNT_W-1:0] need;
    logic [COUNT_W-1:0] done_inc;
    r.st     = s;
    r.again  = 1'b0;
    active   = (s.phase == PH_RELEASE) || (s.phase == PH_PRESS) ||
               (s.phase == PH_UNPRESS) || (s.phase == PH_QUIET);
    if (s.phase == PH_RELEASE) begin
      lim = c.release_ticks;
    end else if (s.phase == PH_QUIET) begin
      lim = s.second_group ? c.quiet_two_ticks : c.quiet_one_ticks;
    end else begin
      lim = (s.presses_done == '0) ? c.first_edge_ticks : c.next_edge_ticks;
    end
    hit = ((s.phase == PH_PRESS) || (s.phase == PH_QUIET)) ? pr : !pr;
    need = s.second_group ? c.second_group_presses : c.first_group_presses;
    if (need == '0) begin
      need = COUNT_W'(1);
    end
    done_inc = s.presses_done + COUNT_W'(1);
    if (active) begin
      if (s.elapsed >= lim) begin
        if (s.phase != PH_QUIET) begin
          r.st.phase = PH_FAILED;
        end else if (s.second_group) begin
          r.st.phase = PH_RECOVERED;
        end else begin
          r.st.second_group = 1'b1;
          r.st.presses_done = '0;
          r.st.elapsed      = '0;
          r.st.phase        = PH_PRESS;
          r.again           = 1'b1;
        end
      end else if (!hit) begin
        r.st.elapsed = s.elapsed + TICK_W'(1);
      end else begin
        r.st.elapsed = '0;
        case (s.phase)
          PH_RELEASE: begin
            r.st.presses_done = '0;
            r.st.phase        = PH_PRESS;
            r.again           = 1'b1;
          end
          PH_PRESS: begin
            r.st.phase = PH_UNPRESS;
            r.again    = 1'b1;
          end
          PH_UNPRESS: begin
            r.st.presses_done = done_inc;
            r.st.phase        = (done_inc >= need) ? PH_QUIET : PH_PRESS;
            r.again           = 1'b1;
          end
          default: begin
            r.st.phase = PH_FAILED;
          end
        endcase
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/button_press_sequence_detector.sv =====
// Top level of the button press sequence detector: input register, state and
// result register around bpsd_step, with configuration held in bpsd_cfg_regs.
`timescale 1ns / 1ps
`default_nettype none

// One button sample is taken per transaction and every sample yields exactly
// one result transaction carrying status and the star stage. The block takes
// a new sample in every clock cycle while its results are taken; a sample is
// held in the input register, goes through the single pass of wait logic and
// its result is held in the result register. While a result waits, one more
// sample can be held in the input register before in_tready drops.
// Configuration writes take effect at once and should be made while no sample
// is in flight.
module button_press_sequence_detector (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: bit 0 pressed, bits 7:1 zero.
  input  wire logic [7:0]                      in_tdata,
  // in_tuser: bit 0 start_req.
  input  wire logic                            in_tuser,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // out_tdata: bits 1:0 status, bits 3:2 stars, bits 7:4 zero.
  output logic [7:0]                           out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_we,
  input  wire logic [bpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpsd_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  bpsd_pkg::cfg_t                   cfg;
  bpsd_pkg::det_state_t             state_r;
  bpsd_pkg::det_state_t             state_nxt;
  logic [bpsd_pkg::STATUS_W-1:0]    status_nxt;
  logic [bpsd_pkg::STARS_W-1:0]     stars_nxt;
  logic                             in_valid_r;
  logic                             in_start_r;
  logic                             in_pressed_r;
  logic                             out_valid_r;
  logic [bpsd_pkg::STATUS_W-1:0]    out_status_r;
  logic [bpsd_pkg::STARS_W-1:0]     out_stars_r;
  logic                             advance;

  bpsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bpsd_step u_step (
    .state     (state_r),
    .cfg       (cfg),
    .start_req (in_start_r),
    .pressed   (in_pressed_r),
    .state_nxt (state_nxt),
    .status    (status_nxt),
    .stars     (stars_nxt)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_start_r   <= in_tuser;
      in_pressed_r <= in_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= bpsd_pkg::PH_IDLE;
      state_r.elapsed      <= '0;
      state_r.presses_done <= '0;
      state_r.second_group <= 1'b0;
      out_valid_r          <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= status_nxt;
      out_stars_r  <= stars_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_stars_r, out_status_r};

endmodule

`default_nettype wire

// ===== hw/rtl/bpsd_cfg_regs.sv =====
// Configuration register file of the button press sequence detector.
// Depends on bpsd_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module bpsd_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpsd_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output bpsd_pkg::cfg_t                       cfg
);

  bpsd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.release_ticks        <= 10'd300;
      cfg_r.first_edge_ticks     <= 10'd200;
      cfg_r.next_edge_ticks      <= 10'd70;
      cfg_r.quiet_one_ticks      <= 10'd100;
      cfg_r.quiet_two_ticks      <= 10'd200;
      cfg_r.first_group_presses  <= 4'd5;
      cfg_r.second_group_presses <= 4'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        bpsd_pkg::REG_RELEASE_TICKS: begin
          cfg_r.release_ticks <= cfg_wdata[bpsd_pkg::TICK_W-1:0];
        end
        bpsd_pkg::REG_FIRST_EDGE_TICKS: begin
          cfg_r.first_edge_ticks <= cfg_wdata[bpsd_pkg::TICK_W-1:0];
        end
        bpsd_pkg::REG_NEXT_EDGE_TICKS: begin
          cfg_r.next_edge_ticks <= cfg_wdata[bpsd_pkg::TICK_W-1:0];
        end
        bpsd_pkg::REG_QUIET_ONE_TICKS: begin
          cfg_r.quiet_one_ticks <= cfg_wdata[bpsd_pkg::TICK_W-1:0];
        end
        bpsd_pkg::REG_QUIET_TWO_TICKS: begin
          cfg_r.quiet_two_ticks <= cfg_wdata[bpsd_pkg::TICK_W-1:0];
        end
        bpsd_pkg::REG_FIRST_GROUP_PRESSES: begin
          cfg_r.first_group_presses <= cfg_wdata[bpsd_pkg::COUNT_W-1:0];
        end
        bpsd_pkg::REG_SECOND_GROUP_PRESSES: begin
          cfg_r.second_group_presses <= cfg_wdata[bpsd_pkg::COUNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bpsd_step.sv =====
// Next-state and result logic for one button sample of the sequence detector.
// Depends on bpsd_pkg for the state bundle, codes and the wait update function.
`timescale 1ns / 1ps
`default_nettype none

module bpsd_step (
  input  wire bpsd_pkg::det_state_t            state,
  input  wire bpsd_pkg::cfg_t                  cfg,
  input  wire logic                            start_req,
  input  wire logic                            pressed,
  output bpsd_pkg::det_state_t                 state_nxt,
  output logic [bpsd_pkg::STATUS_W-1:0]        status,
  output logic [bpsd_pkg::STARS_W-1:0]         stars
);

  bpsd_pkg::det_state_t cur;
  bpsd_pkg::feed_res_t  res;
  logic                 go;

  always_comb begin
    cur = state;
    if (start_req) begin
      cur.second_group = 1'b0;
      cur.presses_done = '0;
      cur.elapsed      = '0;
      cur.phase        = pressed ? bpsd_pkg::PH_RELEASE : bpsd_pkg::PH_FAILED;
    end
    go  = 1'b1;
    res = '0;
    for (int i = 0; i < bpsd_pkg::FEED_STEPS; i++) begin
      if (go) begin
        res = bpsd_pkg::feed(cur, cfg, pressed);
        cur = res.st;
        go  = res.again;
      end
    end
    state_nxt = cur;
  end

  always_comb begin
    case (cur.phase)
      bpsd_pkg::PH_IDLE: begin
        status = bpsd_pkg::STATUS_IDLE;
        stars  = bpsd_pkg::STARS_NONE;
      end
      bpsd_pkg::PH_RECOVERED: begin
        status = bpsd_pkg::STATUS_RECOVERED;
        stars  = bpsd_pkg::STARS_TWO;
      end
      bpsd_pkg::PH_FAILED: begin
        status = bpsd_pkg::STATUS_FAILED;
        stars  = bpsd_pkg::STARS_NONE;
      end
      default: begin
        status = bpsd_pkg::STATUS_BUSY;
        stars  = cur.second_group ? bpsd_pkg::STARS_TWO : bpsd_pkg::STARS_ONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/bpsd_checker.sv =====
// Checker for the button press sequence detector: watches the sample, result and
// register write ports, predicts each result and compares it. Depends on bpsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpsd_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [7:0]                      in_tdata,
  input  wire logic                            in_tuser,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [7:0]                      out_tdata,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_we,
  input  wire logic [bpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bpsd_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output int                                   mismatch_count,
  output int                                   outstanding,
  output int                                   checked_count
);
  import bpsd_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [STARS_W-1:0]  stars;
  } report_t;

  logic [TICK_W-1:0]  release_budget;
  logic [TICK_W-1:0]  first_budget;
  logic [TICK_W-1:0]  next_budget;
  logic [TICK_W-1:0]  quiet_one_budget;
  logic [TICK_W-1:0]  quiet_two_budget;
  logic [COUNT_W-1:0] group_one_size;
  logic [COUNT_W-1:0] group_two_size;

  logic [PHASE_W-1:0] phase_q;
  logic [TICK_W-1:0]  elapsed_q;
  logic [COUNT_W-1:0] presses_q;
  logic               in_group_two;

  report_t expected_reports[$];

  function automatic logic [TICK_W-1:0] current_budget();
    if (phase_q == PH_RELEASE) begin
      return release_budget;
    end
    if (phase_q == PH_QUIET) begin
      return in_group_two ? quiet_two_budget : quiet_one_budget;
    end
    return (presses_q == '0) ? first_budget : next_budget;
  endfunction

  // Returns 1 when the same sample is also the first read of the following wait.
  function automatic bit advance_wait(logic pr);
    logic [TICK_W-1:0]  lim;
    logic               hit;
    logic [COUNT_W-1:0] need;
    if (phase_q != PH_RELEASE && phase_q != PH_PRESS &&
        phase_q != PH_UNPRESS && phase_q != PH_QUIET) begin
      return 1'b0;
    end
    lim = current_budget();
    hit = (phase_q == PH_PRESS || phase_q == PH_QUIET) ? pr : !pr;
    if (elapsed_q >= lim) begin
      if (phase_q != PH_QUIET) begin
        phase_q = PH_FAILED;
        return 1'b0;
      end
      if (in_group_two) begin
        phase_q = PH_RECOVERED;
        return 1'b0;
      end
      in_group_two = 1'b1;
      presses_q = '0;
      elapsed_q = '0;
      phase_q = PH_PRESS;
      return 1'b1;
    end
    if (!hit) begin
      elapsed_q = elapsed_q + 1'b1;
      return 1'b0;
    end
    elapsed_q = '0;
    case (phase_q)
      PH_RELEASE: begin
        presses_q = '0;
        phase_q = PH_PRESS;
        return 1'b1;
      end
      PH_PRESS: begin
        phase_q = PH_UNPRESS;
        return 1'b1;
      end
      PH_UNPRESS: begin
        need = in_group_two ? group_two_size : group_one_size;
        if (need == '0) begin
          need = COUNT_W'(1);
        end
        presses_q = presses_q + 1'b1;
        phase_q = (presses_q >= need) ? PH_QUIET : PH_PRESS;
        return 1'b1;
      end
      default: begin
        phase_q = PH_FAILED;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic report_t predict_report(logic start, logic pr);
    report_t r;
    if (start) begin
      in_group_two = 1'b0;
      presses_q = '0;
      elapsed_q = '0;
      phase_q = pr ? PH_RELEASE : PH_FAILED;
    end
    for (int step = 0; step < 8; step++) begin
      if (!advance_wait(pr)) begin
        break;
      end
    end
    case (phase_q)
      PH_IDLE: begin
        r.status = STATUS_IDLE;
        r.stars = STARS_NONE;
      end
      PH_RECOVERED: begin
        r.status = STATUS_RECOVERED;
        r.stars = STARS_TWO;
      end
      PH_FAILED: begin
        r.status = STATUS_FAILED;
        r.stars = STARS_NONE;
      end
      default: begin
        r.status = STATUS_BUSY;
        r.stars = in_group_two ? STARS_TWO : STARS_ONE;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    report_t want;
    report_t got;
    if (!rst_n) begin
      release_budget = 10'd300;
      first_budget = 10'd200;
      next_budget = 10'd70;
      quiet_one_budget = 10'd100;
      quiet_two_budget = 10'd200;
      group_one_size = 4'd5;
      group_two_size = 4'd6;
      phase_q = PH_IDLE;
      elapsed_q = '0;
      presses_q = '0;
      in_group_two = 1'b0;
      expected_reports.delete();
      mismatch_count = 0;
      checked_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RELEASE_TICKS:        release_budget = cfg_wdata[TICK_W-1:0];
          REG_FIRST_EDGE_TICKS:     first_budget = cfg_wdata[TICK_W-1:0];
          REG_NEXT_EDGE_TICKS:      next_budget = cfg_wdata[TICK_W-1:0];
          REG_QUIET_ONE_TICKS:      quiet_one_budget = cfg_wdata[TICK_W-1:0];
          REG_QUIET_TWO_TICKS:      quiet_two_budget = cfg_wdata[TICK_W-1:0];
          REG_FIRST_GROUP_PRESSES:  group_one_size = cfg_wdata[COUNT_W-1:0];
          REG_SECOND_GROUP_PRESSES: group_two_size = cfg_wdata[COUNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.stars = out_tdata[3:2];
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected transaction, status %0d stars %0d",
                   $time, got.status, got.stars);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          checked_count++;
          if (got.status != want.status) begin
            $display("%0t: status expected %0d, actual %0d",
                     $time, want.status, got.status);
            mismatch_count++;
          end
          if (got.stars != want.stars) begin
            $display("%0t: stars expected %0d, actual %0d",
                     $time, want.stars, got.stars);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_reports.push_back(predict_report(in_tuser, in_tdata[0]));
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

`default_nettype wire

// ===== tb/sv/button_press_sequence_detector_test.sv =====
// Top of the button press sequence detector testbench: clock, reset, sample and
// register stimulus, output back-pressure and the verdict. Uses bpsd_checker.
`timescale 1ns / 1ps
`default_nettype none

module button_press_sequence_detector_test;
  import bpsd_pkg::*;

  localparam int SAMPLE_GOAL = 1150;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic [7:0]           in_tdata = 8'd0;
  logic                 in_tuser = 1'b0;
  logic                 in_tvalid = 1'b0;
  wire logic            in_tready;
  wire logic [7:0]      out_tdata;
  wire logic            out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int outstanding;
  int checked_count;

  int samples_sent = 0;
  int settings_made = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit hold_output = 1'b0;

  int release_len;
  int first_len;
  int next_len;
  int quiet_one_len;
  int quiet_two_len;
  int group_one_len;
  int group_two_len;

  button_press_sequence_detector i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  bpsd_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .checked_count  (checked_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : result_side
    int gap;
    int taken;
    taken = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_output) begin
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_output = 1'b0;
      end
      if (taken % 40 == 0) begin
        recv_burst = ($urandom_range(0, 2) == 0);
      end
      gap = recv_burst ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      taken++;
      @(negedge clk);
    end
  end

  task automatic send_sample(input logic start, input logic pr);
    int gap;
    if (samples_sent % 50 == 0) begin
      send_burst = ($urandom_range(0, 2) == 0);
    end
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {7'd0, pr};
    in_tuser <= start;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic pr, input int count);
    repeat (count) send_sample(1'b0, pr);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DAT_W-1:0];
    @(negedge clk);
  endtask

  task automatic apply_settings(input int rel, input int first, input int next,
                                input int q1, input int q2, input int g1, input int g2);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    write_reg(REG_RELEASE_TICKS, rel);
    write_reg(REG_FIRST_EDGE_TICKS, first);
    write_reg(REG_NEXT_EDGE_TICKS, next);
    write_reg(REG_QUIET_ONE_TICKS, q1);
    write_reg(REG_QUIET_TWO_TICKS, q2);
    write_reg(REG_FIRST_GROUP_PRESSES, g1);
    write_reg(REG_SECOND_GROUP_PRESSES, g2);
    cfg_we <= 1'b0;
    release_len = rel;
    first_len = first;
    next_len = next;
    quiet_one_len = q1;
    quiet_two_len = q2;
    group_one_len = g1;
    group_two_len = g2;
    settings_made++;
  endtask

  // Length of a run of equal samples for a wait with the given budget: mostly
  // inside the budget, sometimes right at its last chance or past it.
  function automatic int pick_run(input int budget);
    int roll;
    int longest;
    if (budget < 2) begin
      return 1;
    end
    roll = $urandom_range(0, 39);
    longest = (budget - 1 < 12) ? budget - 1 : 12;
    if (budget <= 40 && roll == 0) begin
      return budget;
    end
    if (budget <= 40 && roll == 1) begin
      return budget + $urandom_range(1, 5);
    end
    if (budget <= 40 && roll <= 3) begin
      return budget - 1;
    end
    return $urandom_range(1, longest);
  endfunction

  function automatic int pick_quiet(input int budget);
    if (budget > 40) begin
      return $urandom_range(1, 30);
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, budget);
    end
    return budget;
  endfunction

  function automatic int pick_budget();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) begin
      return 2;
    end
    if (roll == 1) begin
      return 1023;
    end
    if (roll == 2) begin
      return $urandom_range(0, 1);
    end
    return $urandom_range(2, 12);
  endfunction

  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return 15;
    end
    if (roll == 1) begin
      return 0;
    end
    if (roll == 2) begin
      return 1;
    end
    return $urandom_range(1, 6);
  endfunction

  task automatic play_gesture();
    int need_one;
    int need_two;
    int budget;
    if ($urandom_range(0, 11) == 0) begin
      send_sample(1'b1, 1'b0);
      return;
    end
    need_one = (group_one_len == 0) ? 1 : group_one_len;
    need_two = (group_two_len == 0) ? 1 : group_two_len;
    send_sample(1'b1, 1'b1);
    send_run(1'b1, pick_run(release_len) - 1);
    for (int i = 0; i < need_one; i++) begin
      budget = (i == 0) ? first_len : next_len;
      send_run(1'b0, pick_run(budget));
      send_run(1'b1, pick_run(budget));
    end
    for (int i = 0; i < need_two; i++) begin
      budget = (i == 0) ? first_len : next_len;
      if (i == 0) begin
        send_run(1'b0, pick_quiet(quiet_one_len) + pick_run(budget));
      end else begin
        send_run(1'b0, pick_run(budget));
      end
      send_run(1'b1, pick_run(budget));
    end
    send_run(1'b0, pick_quiet(quiet_two_len) + 1);
  endtask

  task automatic stray_samples();
    repeat ($urandom_range(0, 4)) begin
      send_sample($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Power-on settings: idle samples, start without the button, restart.
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);

    // Zero and one tick budgets with empty groups.
    apply_settings(0, 0, 0, 0, 0, 0, 0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    apply_settings(1, 1, 1, 1, 1, 0, 0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);

    // Shortest budgets: a complete gesture that is recognized.
    apply_settings(2, 2, 2, 2, 2, 0, 0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    send_run(1'b0, 3);
    send_sample(1'b0, 1'b1);
    send_run(1'b0, 3);
    send_sample(1'b0, 1'b1);

    apply_settings(1023, 1023, 1023, 1023, 1023, 15, 15);
    play_gesture();
    apply_settings(2, 2, 2, 2, 2, 1, 1);
    play_gesture();

    while (samples_sent < SAMPLE_GOAL) begin
      apply_settings(pick_budget(), pick_budget(), pick_budget(), pick_budget(),
                     pick_budget(), pick_size(), pick_size());
      if (settings_made == 7) begin
        hold_output = 1'b1;
      end
      repeat ($urandom_range(2, 5)) begin
        if (samples_sent < SAMPLE_GOAL) begin
          stray_samples();
          play_gesture();
        end
      end
    end

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d samples under %0d register settings; %0d results checked.",
             samples_sent, settings_made, checked_count);
    $display("Covered gestures, broken gestures, restarts, extreme budgets and a long stall.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/bpsd_pkg.sv
hw/rtl/bpsd_cfg_regs.sv
hw/rtl/bpsd_step.sv
hw/rtl/button_press_sequence_detector.sv
tb/sv/bpsd_checker.sv
tb/sv/button_press_sequence_detector_test.sv
